@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define REDA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define REDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/reda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reda_pkg
// Shared constants, codes and controller/datapath interface types for the
// routing edge demand accumulator.
// ----------------------------------------------------------------------------
package reda_pkg;

  // Parameter defaults
  localparam int GRID_COLS_DEF   = 64;
  localparam int GRID_ROWS_DEF   = 64;
  localparam int LAYERS_DEF      = 8;
  localparam int DEMAND_BITS_DEF = 16;

  // Port widths
  localparam int TDATA_IN_W  = 128;
  localparam int TUSER_IN_W  = 1;
  localparam int TDATA_OUT_W = 32;
  localparam int TUSER_OUT_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Field widths
  localparam int COORD_W  = 24;
  localparam int SIZE_W   = 16;
  localparam int CNT_W    = 7;
  localparam int LCNT_W   = 4;
  localparam int LAYER_W  = 8;
  localparam int RC_W     = 6;
  localparam int EDGES_W  = 6;
  localparam int TOTAL_W  = 19;
  localparam int DIV_STEPS = 24;

  localparam logic [EDGES_W-1:0] EDGES_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Register reset values
  localparam logic [COORD_W-1:0] ORIGIN_X_RST = '0;
  localparam logic [COORD_W-1:0] ORIGIN_Y_RST = '0;
  localparam logic [SIZE_W-1:0]  TILE_W_RST   = 16'd1;
  localparam logic [SIZE_W-1:0]  TILE_H_RST   = 16'd1;
  localparam logic [CNT_W-1:0]   COLS_RST     = 7'd64;
  localparam logic [CNT_W-1:0]   ROWS_RST     = 7'd64;
  localparam logic [LCNT_W-1:0]  LAYERS_RST   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_TILE_W   = 3'd2,
    CFG_TILE_H   = 3'd3,
    CFG_COLS     = 3'd4,
    CFG_ROWS     = 3'd5,
    CFG_LAYERS   = 3'd6
  } cfg_idx_t;

  typedef enum logic [TUSER_OUT_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_VIA         = 3'd1,
    ST_SKIPPED     = 3'd2,
    ST_NOT_ALIGNED = 3'd3,
    ST_READ_DONE   = 3'd4
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic       clr;
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       classify;
    logic       addr_a;
    logic       addr_b;
    logic       bump;
    logic       acc;
    logic       out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic is_read;
    logic walk;
    logic walk_last;
    logic rd_go;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/reda_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reda_div
// Restoring divider, one quotient bit per cycle, zero divisor taken as one.
// ----------------------------------------------------------------------------
module reda_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [reda_pkg::COORD_W-1:0]        dividend,
  input  logic [reda_pkg::SIZE_W-1:0]         divisor,
  output logic                                done,
  output logic [reda_pkg::COORD_W-1:0]        quot
);

  localparam int SW = $clog2(reda_pkg::DIV_STEPS + 1);

  logic                          busy;
  logic [SW-1:0]                 cnt;
  logic [reda_pkg::SIZE_W-1:0]   rem;
  logic [reda_pkg::COORD_W-1:0]  dvd;
  logic [reda_pkg::SIZE_W-1:0]   dsr;
  logic [reda_pkg::SIZE_W:0]     trial;
  logic [reda_pkg::SIZE_W:0]     diff;
  logic                          ge;

  always_comb begin
    trial = {rem, dvd[reda_pkg::COORD_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SW'(reda_pkg::DIV_STEPS);
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= (divisor == '0) ? reda_pkg::SIZE_W'(1) : divisor;
      end else if (busy) begin
        rem <= ge ? diff[reda_pkg::SIZE_W-1:0] : trial[reda_pkg::SIZE_W-1:0];
        dvd <= {dvd[reda_pkg::COORD_W-2:0], ge};
        cnt <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dvd;

endmodule

@@ rtl/reda_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reda_dp
// Datapath: config registers, tile mapping, segment classification, address
// generation, demand memories and the output register.
// ----------------------------------------------------------------------------
module reda_dp #(
  parameter int GRID_COLS   = reda_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = reda_pkg::GRID_ROWS_DEF,
  parameter int LAYERS      = reda_pkg::LAYERS_DEF,
  parameter int DEMAND_BITS = reda_pkg::DEMAND_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [reda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [reda_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [reda_pkg::TDATA_IN_W-1:0]      s_tdata,
  input  logic [reda_pkg::TUSER_IN_W-1:0]      s_tuser,
  input  reda_pkg::cmd_t                       cmd,
  output reda_pkg::sts_t                       sts,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [reda_pkg::TDATA_OUT_W-1:0]     m_tdata,
  output logic [reda_pkg::TUSER_OUT_W-1:0]     m_tuser
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS * LAYERS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CR    = $clog2(GRID_COLS * GRID_ROWS);
  localparam int ZW    = $clog2(LAYERS + 1);
  localparam int QW    = 26;   // signed tile coordinate
  localparam int KW    = 11;   // walk index, holds up to 2047
  localparam int AccW  = DEMAND_BITS + ZW;

  // Config registers
  logic [reda_pkg::COORD_W-1:0] org_x, org_y;
  logic [reda_pkg::SIZE_W-1:0]  tile_w, tile_h;
  logic [reda_pkg::CNT_W-1:0]   cols, rows;
  logic [reda_pkg::LCNT_W-1:0]  lyrs;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x  <= reda_pkg::ORIGIN_X_RST;
      org_y  <= reda_pkg::ORIGIN_Y_RST;
      tile_w <= reda_pkg::TILE_W_RST;
      tile_h <= reda_pkg::TILE_H_RST;
      cols   <= reda_pkg::COLS_RST;
      rows   <= reda_pkg::ROWS_RST;
      lyrs   <= reda_pkg::LAYERS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        reda_pkg::CFG_ORIGIN_X: org_x  <= cfg_data;
        reda_pkg::CFG_ORIGIN_Y: org_y  <= cfg_data;
        reda_pkg::CFG_TILE_W:   tile_w <= cfg_data[reda_pkg::SIZE_W-1:0];
        reda_pkg::CFG_TILE_H:   tile_h <= cfg_data[reda_pkg::SIZE_W-1:0];
        reda_pkg::CFG_COLS:     cols   <= cfg_data[reda_pkg::CNT_W-1:0];
        reda_pkg::CFG_ROWS:     rows   <= cfg_data[reda_pkg::CNT_W-1:0];
        reda_pkg::CFG_LAYERS:   lyrs   <= cfg_data[reda_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped grid sizes
  logic [KW-1:0] x_cnt, y_cnt;
  logic [ZW-1:0] z_cnt;
  logic signed [QW-1:0] xs, ys;

  always_comb begin
    x_cnt = (KW'(cols) > KW'(GRID_COLS)) ? KW'(GRID_COLS) : KW'(cols);
    y_cnt = (KW'(rows) > KW'(GRID_ROWS)) ? KW'(GRID_ROWS) : KW'(rows);
    z_cnt = (5'(lyrs) > 5'(LAYERS)) ? ZW'(LAYERS) : ZW'(lyrs);
    xs    = QW'(x_cnt);
    ys    = QW'(y_cnt);
  end

  // Latched item
  logic                          op_r, rv;
  logic [reda_pkg::COORD_W-1:0]  x1, y1, x2, y2;
  logic [reda_pkg::LAYER_W-1:0]  l1, l2;
  logic [reda_pkg::RC_W-1:0]     rc, rr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= s_tuser[0];
      x1   <= s_tdata[23:0];
      y1   <= s_tdata[47:24];
      l1   <= s_tdata[55:48];
      x2   <= s_tdata[79:56];
      y2   <= s_tdata[103:80];
      l2   <= s_tdata[111:104];
      rc   <= s_tdata[117:112];
      rr   <= s_tdata[123:118];
      rv   <= s_tdata[124];
    end
  end

  // Tile mapping through the shared divider
  logic [reda_pkg::COORD_W-1:0] raw, org, mag, quot;
  logic [reda_pkg::SIZE_W-1:0]  tsz;
  logic [reda_pkg::COORD_W:0]   dif, dneg;
  logic                          neg, div_done;
  logic signed [QW-1:0]          qs;
  logic signed [QW-1:0]          qx1, qy1, qx2, qy2;

  always_comb begin
    unique case (cmd.div_sel)
      2'd0:    raw = x1;
      2'd1:    raw = y1;
      2'd2:    raw = x2;
      default: raw = y2;
    endcase
    org  = cmd.div_sel[0] ? org_y : org_x;
    tsz  = cmd.div_sel[0] ? tile_h : tile_w;
    dif  = {1'b0, raw} - {1'b0, org};
    dneg = -dif;
    neg  = dif[reda_pkg::COORD_W];
    mag  = neg ? dneg[reda_pkg::COORD_W-1:0] : dif[reda_pkg::COORD_W-1:0];
    qs   = neg ? -QW'(quot) : QW'(quot);
  end

  reda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (tsz),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.div_sel)
        2'd0:    qx1 <= qs;
        2'd1:    qy1 <= qs;
        2'd2:    qx2 <= qs;
        default: qy2 <= qs;
      endcase
    end
  end

  // Segment classification
  reda_pkg::status_t    kind;
  logic                 same_x, same_y, layer_ok, walk_c;
  logic signed [QW-1:0] a, b, amin, bmax, lo, hi, wl, fl, fixd;

  always_comb begin
    same_x   = qx1 == qx2;
    same_y   = qy1 == qy2;
    layer_ok = (l1 != '0) && (l1 <= reda_pkg::LAYER_W'(z_cnt));
    priority if (l1 != l2) kind = reda_pkg::ST_VIA;
    else if ((same_x && same_y) || !layer_ok) kind = reda_pkg::ST_SKIPPED;
    else if (same_y || same_x) kind = reda_pkg::ST_ADDED;
    else kind = reda_pkg::ST_NOT_ALIGNED;
    a      = same_y ? qx1 : qy1;
    b      = same_y ? qx2 : qy2;
    fixd   = same_y ? qy1 : qx1;
    amin   = (a < b) ? a : b;
    bmax   = (a < b) ? b : a;
    lo     = (amin < 0) ? '0 : amin;
    wl     = same_y ? xs - QW'(1) : ys - QW'(1);
    fl     = same_y ? ys : xs;
    hi     = (bmax < wl) ? bmax : wl;
    walk_c = (kind == reda_pkg::ST_ADDED) && (fixd >= 0) && (fixd < fl) && (lo < hi);
  end

  reda_pkg::status_t status_r;
  logic              horiz, use_vert, walk_r;
  logic [KW-1:0]     k, hi_r, fix_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      use_vert <= s_tdata[124];
      walk_r   <= 1'b0;
      status_r <= reda_pkg::ST_READ_DONE;
    end else if (cmd.classify) begin
      status_r <= kind;
      horiz    <= same_y;
      use_vert <= !same_y;
      walk_r   <= walk_c;
      k        <= lo[KW-1:0];
      hi_r     <= hi[KW-1:0];
      fix_r    <= fixd[KW-1:0];
    end else if (cmd.bump) begin
      k <= k + KW'(1);
    end
  end

  // Read range check
  logic signed [QW-1:0] cs, rs;
  logic                 rd_ok;

  always_comb begin
    cs    = QW'(rc);
    rs    = QW'(rr);
    rd_ok = rv ? ((cs < xs) && (rs < ys - QW'(1)))
               : ((cs < xs - QW'(1)) && (rs < ys));
  end

  // Address generation
  logic [KW-1:0] xsel, ysel;
  logic [CR-1:0] tmp;
  logic [AW-1:0] addr, zsel, stride;
  logic [ZW-1:0] lyr;

  always_comb begin
    if (op_r) begin
      xsel = KW'(rc);
      ysel = KW'(rr);
    end else if (horiz) begin
      xsel = k;
      ysel = fix_r;
    end else begin
      xsel = fix_r;
      ysel = k;
    end
    zsel = op_r ? '0 : AW'(l1 - reda_pkg::LAYER_W'(1));
    if (op_r) stride = AW'(1);
    else if (horiz) stride = AW'(GRID_ROWS * LAYERS);
    else stride = AW'(LAYERS);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_a) begin
      tmp <= CR'(CR'(xsel[CW-1:0]) * CR'(GRID_ROWS)) + CR'(ysel[RW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.clr) begin
      addr <= addr + AW'(1);
    end else if (cmd.addr_b) begin
      addr <= AW'(AW'(tmp) * AW'(LAYERS)) + zsel;
    end else if (cmd.bump || cmd.acc) begin
      addr <= addr + stride;
    end
  end

  // Demand memories
  logic [DEMAND_BITS-1:0] hmem [DEPTH];
  logic [DEMAND_BITS-1:0] vmem [DEPTH];
  logic [DEMAND_BITS-1:0] hrd, vrd, cur, wdat;
  logic                   h_we, v_we;

  always_comb begin
    cur  = use_vert ? vrd : hrd;
    wdat = cmd.clr ? '0 : ((&cur) ? cur : cur + DEMAND_BITS'(1));
    h_we = cmd.clr || (cmd.bump && !use_vert);
    v_we = cmd.clr || (cmd.bump && use_vert);
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[addr] <= wdat;
    hrd <= hmem[addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[addr] <= wdat;
    vrd <= vmem[addr];
  end

  // Counters and accumulator
  logic [KW-1:0]   n;
  logic [AccW-1:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= '0;
      acc <= '0;
      lyr <= '0;
    end else begin
      if (cmd.bump) n <= n + KW'(1);
      if (cmd.acc) begin
        acc <= acc + AccW'(cur);
        lyr <= lyr + ZW'(1);
      end
    end
  end

  // Output register
  logic [reda_pkg::EDGES_W-1:0] edges_o;
  logic [reda_pkg::TOTAL_W-1:0] total_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= status_r;
      edges_o <= (n > KW'(reda_pkg::EDGES_MAX)) ? reda_pkg::EDGES_MAX
                                                : n[reda_pkg::EDGES_W-1:0];
      total_o <= (acc > AccW'(reda_pkg::TOTAL_MAX)) ? reda_pkg::TOTAL_MAX
                                                    : reda_pkg::TOTAL_W'(acc);
    end
  end

  assign m_tdata = {7'd0, total_o, edges_o};

  always_comb begin
    sts.clr_last  = addr == AW'(DEPTH - 1);
    sts.div_done  = div_done;
    sts.is_read   = op_r;
    sts.walk      = walk_r;
    sts.walk_last = (k + KW'(1)) == hi_r;
    sts.rd_go     = rd_ok && (z_cnt != '0);
    sts.sum_last  = lyr == (z_cnt - ZW'(1));
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

@@ rtl/reda_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reda_ctrl
// Sequencer: clearing pass, tile mapping, edge walk, layer sum, result hand-off.
// ----------------------------------------------------------------------------
module reda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  reda_pkg::sts_t  sts,
  output reda_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_CLASS, S_CHECK, S_RCHK,
    S_ADDR_A, S_ADDR_B, S_RD, S_WR, S_SRD, S_SACC, S_FINISH
  } state_t;

  state_t     state, state_next;
  logic [1:0] sel, sel_next;
  logic       rdy;

  always_comb begin
    state_next   = state;
    sel_next     = sel;
    cmd          = '0;
    cmd.div_sel  = sel;
    cmd.load     = s_tvalid && rdy;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid && rdy) begin
          sel_next   = 2'd0;
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        if (sts.is_read) state_next = sts.rd_go ? S_ADDR_A : S_FINISH;
        else state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          if (sel == 2'd3) begin
            state_next = S_CLASS;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = S_DIV_GO;
          end
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: state_next = sts.walk ? S_ADDR_A : S_FINISH;
      S_ADDR_A: begin
        cmd.addr_a = 1'b1;
        state_next = S_ADDR_B;
      end
      S_ADDR_B: begin
        cmd.addr_b = 1'b1;
        state_next = sts.is_read ? S_SRD : S_RD;
      end
      S_RD: state_next = S_WR;
      S_WR: begin
        cmd.bump   = 1'b1;
        state_next = sts.walk_last ? S_FINISH : S_RD;
      end
      S_SRD: state_next = S_SACC;
      S_SACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.sum_last ? S_FINISH : S_SRD;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sel   <= 2'd0;
      rdy   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      rdy   <= (state_next == S_IDLE) && !(state == S_IDLE && s_tvalid && rdy);
    end
  end

  assign s_tready = rdy;

endmodule

@@ rtl/routing_edge_demand_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// routing_edge_demand_accumulator_top
// Per-layer horizontal and vertical edge demand grids with segment adds and
// summed edge reads.
// ----------------------------------------------------------------------------
// One item is in flight at a time. After reset the block runs a clearing pass
// over all GRID_COLS*GRID_ROWS*LAYERS addresses of both demand memories (32768
// at the defaults), with s_tready low; config writes are taken during it. An add
// maps its four endpoint coordinates in turn through one shared bit-serial
// divider, classifies the segment, then sets up the edge address and walks its
// unit edges with a read-modify-write on one memory port. A read sums one memory
// read per layer over the Z layers in use. A finished result sits in the output
// register while the next item is accepted.
module routing_edge_demand_accumulator_top #(
  parameter int GRID_COLS   = reda_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = reda_pkg::GRID_ROWS_DEF,
  parameter int LAYERS      = reda_pkg::LAYERS_DEF,
  parameter int DEMAND_BITS = reda_pkg::DEMAND_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [reda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [reda_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // seg_x1, seg_y1, seg_layer1, seg_x2, seg_y2, seg_layer2, read_col,
  // read_row, read_vertical, zero pad
  input  logic [reda_pkg::TDATA_IN_W-1:0]   s_tdata,
  input  logic [reda_pkg::TUSER_IN_W-1:0]   s_tuser,   // op
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [reda_pkg::TDATA_OUT_W-1:0]  m_tdata,   // edges_added, demand_total, pad
  output logic [reda_pkg::TUSER_OUT_W-1:0]  m_tuser    // status
);

  reda_pkg::cmd_t cmd;
  reda_pkg::sts_t sts;

  // Config registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  reda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  reda_dp #(
    .GRID_COLS   (GRID_COLS),
    .GRID_ROWS   (GRID_ROWS),
    .LAYERS      (LAYERS),
    .DEMAND_BITS (DEMAND_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ rtl/reda_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reda_chk
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reda_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [reda_pkg::TDATA_OUT_W-1:0]  m_tdata,
  input logic [reda_pkg::TUSER_OUT_W-1:0]  m_tuser
);

  `REDA_ASSERT(a_status_code, clk, rst,
    m_tvalid |-> (m_tuser <= reda_pkg::ST_READ_DONE), "bad status code")

  `REDA_ASSERT(a_read_no_edges, clk, rst,
    (m_tvalid && m_tuser == reda_pkg::ST_READ_DONE) |-> (m_tdata[5:0] == '0),
    "read result carries edge count")

  `REDA_ASSERT(a_add_no_total, clk, rst,
    (m_tvalid && m_tuser != reda_pkg::ST_READ_DONE) |-> (m_tdata[24:6] == '0),
    "add result carries demand total")

  `REDA_ASSERT(a_idle_no_edges, clk, rst,
    (m_tvalid && (m_tuser == reda_pkg::ST_VIA || m_tuser == reda_pkg::ST_SKIPPED ||
     m_tuser == reda_pkg::ST_NOT_ALIGNED)) |-> (m_tdata[5:0] == '0),
    "rejected segment counted edges")

  `REDA_ASSERT(a_out_hold, clk, rst,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
    "stalled result changed")

endmodule

bind routing_edge_demand_accumulator_top reda_chk u_reda_chk (.*);

@@ tb/routing_edge_demand_accumulator_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// routing_edge_demand_accumulator_top_test
// Self-checking bench: drives add and read transactions through the input
// stream, predicts every result with a local model of the demand grids and
// compares it field by field against the result stream.
// ----------------------------------------------------------------------------
module routing_edge_demand_accumulator_top_test;

  localparam int NCOLS = reda_pkg::GRID_COLS_DEF;
  localparam int NROWS = reda_pkg::GRID_ROWS_DEF;
  localparam int NLAY  = reda_pkg::LAYERS_DEF;
  localparam int NCELL = NCOLS * NROWS * NLAY;
  localparam int DMAX  = (1 << reda_pkg::DEMAND_BITS_DEF) - 1;
  localparam int WATCHDOG_CYCLES = 400000;  // covers the clearing pass after reset

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                          op;
    logic [reda_pkg::COORD_W-1:0]  x1, y1;
    logic [reda_pkg::LAYER_W-1:0]  l1;
    logic [reda_pkg::COORD_W-1:0]  x2, y2;
    logic [reda_pkg::LAYER_W-1:0]  l2;
    logic [reda_pkg::RC_W-1:0]     col, row;
    logic                          vert;
  } seg_item_t;

  typedef struct packed {
    reda_pkg::status_t             status;
    logic [reda_pkg::EDGES_W-1:0]  edges;
    logic [reda_pkg::TOTAL_W-1:0]  total;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [reda_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [reda_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [reda_pkg::TDATA_IN_W-1:0] s_tdata = '0;
  logic [reda_pkg::TUSER_IN_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [reda_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic [reda_pkg::TUSER_OUT_W-1:0] m_tuser;

  routing_edge_demand_accumulator_top dut (.*);

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local model state: per-layer demand counters and register copies.
  // --------------------------------------------------------------------------
  int unsigned horiz_cnt[NCELL];
  int unsigned vert_cnt[NCELL];
  longint org_x, org_y, tw, th, ncols, nrows, nlay;

  seg_item_t    pending_items[$];
  edge_result_t expected_results[$];
  int  mismatches = 0;
  int  stall_left = 0;   // idle burst counters
  int  bp_left = 0;
  bit  quiet = 1'b0;     // no idling in the last part
  bit  busy_cfg = 1'b0;
  bit  in_fire = 1'b0;   // input transaction taken at the last rising edge
  int  idle_cycles = 0;

  function automatic int cell_at(longint x, longint y, longint z);
    return int'((x * NROWS + y) * NLAY + z);
  endfunction

  function automatic longint tile_of(longint raw, longint org, longint size);
    longint s;
    s = (size == 0) ? 1 : size;
    return (raw - org) / s;  // SV division truncates toward zero
  endfunction

  // Applies one item to the model grids and returns the result it yields.
  function automatic edge_result_t apply_demand(seg_item_t it);
    edge_result_t r;
    longint X, Y, Z, x1, y1, x2, y2, z1, z2, a, b, fixd, wl, fl, lo, hi, tot, n;
    bit hz, ok;
    X = (ncols > NCOLS) ? NCOLS : ncols;
    Y = (nrows > NROWS) ? NROWS : nrows;
    Z = (nlay > NLAY) ? NLAY : nlay;
    r = '0;
    if (it.op == OP_READ) begin
      tot = 0;
      ok = it.vert ? (it.col < X && it.row < Y - 1) : (it.col < X - 1 && it.row < Y);
      if (ok) begin
        for (longint z = 0; z < Z; z++)
          tot += it.vert ? vert_cnt[cell_at(it.col, it.row, z)]
                         : horiz_cnt[cell_at(it.col, it.row, z)];
      end
      r.total = (tot > reda_pkg::TOTAL_MAX) ? reda_pkg::TOTAL_MAX
                                            : tot[reda_pkg::TOTAL_W-1:0];
      r.status = reda_pkg::ST_READ_DONE;
      return r;
    end
    x1 = tile_of(it.x1, org_x, tw);
    y1 = tile_of(it.y1, org_y, th);
    x2 = tile_of(it.x2, org_x, tw);
    y2 = tile_of(it.y2, org_y, th);
    z1 = longint'(it.l1) - 1;
    z2 = longint'(it.l2) - 1;
    if (z1 != z2) r.status = reda_pkg::ST_VIA;
    else if ((x1 == x2 && y1 == y2) || z1 < 0 || z1 >= Z) r.status = reda_pkg::ST_SKIPPED;
    else if (y1 == y2 || x1 == x2) begin
      hz = (y1 == y2);
      a = hz ? x1 : y1;
      b = hz ? x2 : y2;
      fixd = hz ? y1 : x1;
      wl = hz ? X - 1 : Y - 1;
      fl = hz ? Y : X;
      if (a > b) begin
        lo = a; a = b; b = lo;
      end
      lo = (a < 0) ? 0 : a;
      hi = (b < wl) ? b : wl;
      n = 0;
      if (fixd >= 0 && fixd < fl) begin
        for (longint k = lo; k < hi; k++) begin
          if (hz) begin
            if (horiz_cnt[cell_at(k, fixd, z1)] < DMAX) horiz_cnt[cell_at(k, fixd, z1)]++;
          end else begin
            if (vert_cnt[cell_at(fixd, k, z1)] < DMAX) vert_cnt[cell_at(fixd, k, z1)]++;
          end
          n++;
        end
      end
      r.edges = (n > reda_pkg::EDGES_MAX) ? reda_pkg::EDGES_MAX : n[reda_pkg::EDGES_W-1:0];
      r.status = reda_pkg::ST_ADDED;
    end else r.status = reda_pkg::ST_NOT_ALIGNED;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued items at the falling edge, idles in bursts.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst || busy_cfg) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
      // holding the current transaction
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      s_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 7) - 1;
      s_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      s_tvalid <= 1'b1;
      s_tuser <= pending_items[0].op;
      s_tdata <= {3'b0, pending_items[0].vert, pending_items[0].row,
                  pending_items[0].col, pending_items[0].l2, pending_items[0].y2,
                  pending_items[0].x2, pending_items[0].l1, pending_items[0].y1,
                  pending_items[0].x1};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Accepted input: predict and drop from the pending queue.
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(apply_demand(pending_items.pop_front()));
    end
  end

  // Result side backpressure, in bursts.
  always @(negedge clk) begin
    if (bp_left > 0) begin
      bp_left <= bp_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      bp_left <= $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares each result transaction with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    edge_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = reda_pkg::status_t'(m_tuser);
      got.edges = m_tdata[reda_pkg::EDGES_W-1:0];
      got.total = m_tdata[reda_pkg::EDGES_W +: reda_pkg::TOTAL_W];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d edges %0d total %0d",
                   got.status, got.edges, got.total);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d edges %0d total %0d, got %0d %0d %0d",
                     want.status, want.edges, want.total,
                     got.status, got.edges, got.total);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("routing_edge_demand_accumulator_top_test: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(reda_pkg::cfg_idx_t idx, logic [reda_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      reda_pkg::CFG_ORIGIN_X: org_x = val;
      reda_pkg::CFG_ORIGIN_Y: org_y = val;
      reda_pkg::CFG_TILE_W:   tw = val[reda_pkg::SIZE_W-1:0];
      reda_pkg::CFG_TILE_H:   th = val[reda_pkg::SIZE_W-1:0];
      reda_pkg::CFG_COLS:     ncols = val[reda_pkg::CNT_W-1:0];
      reda_pkg::CFG_ROWS:     nrows = val[reda_pkg::CNT_W-1:0];
      reda_pkg::CFG_LAYERS:   nlay = val[reda_pkg::LCNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for all items and results, then blocks further items and lets
  // the walk settle.
  task automatic drain;
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    busy_cfg = 1'b1;
    repeat (300) @(posedge clk);
  endtask

  task automatic program_grid(longint ox, oy, w, h, c, r, l);
    write_reg(reda_pkg::CFG_ORIGIN_X, ox);
    write_reg(reda_pkg::CFG_ORIGIN_Y, oy);
    write_reg(reda_pkg::CFG_TILE_W, w);
    write_reg(reda_pkg::CFG_TILE_H, h);
    write_reg(reda_pkg::CFG_COLS, c);
    write_reg(reda_pkg::CFG_ROWS, r);
    write_reg(reda_pkg::CFG_LAYERS, l);
  endtask

  function automatic seg_item_t add_item(longint x1, y1, x2, y2, l1, l2);
    seg_item_t it;
    it = '0;
    it.op = OP_ADD;
    it.x1 = x1; it.y1 = y1; it.x2 = x2; it.y2 = y2; it.l1 = l1; it.l2 = l2;
    it.col = $urandom; it.row = $urandom; it.vert = $urandom;  // ignored on adds
    return it;
  endfunction

  function automatic seg_item_t read_item(int c, r, v);
    seg_item_t it;
    it = seg_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});  // noise
    it.op = OP_READ;
    it.col = c; it.row = r; it.vert = v;
    return it;
  endfunction

  // Random item in raw units; mostly aligned segments inside the grid.
  function automatic seg_item_t random_item();
    seg_item_t it;
    longint sx, sy, ex, ey, ly;
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) return read_item($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
    sx = org_x + $urandom_range(0, 70) * tw - $urandom_range(0, 2) * tw + $urandom_range(0, tw - 1);
    sy = org_y + $urandom_range(0, 70) * th - $urandom_range(0, 2) * th + $urandom_range(0, th - 1);
    ex = sx; ey = sy;
    if ($urandom_range(0, 1)) ex = org_x + $urandom_range(0, 70) * tw;
    else ey = org_y + $urandom_range(0, 70) * th;
    if (k > 92) begin
      ex = org_x + $urandom_range(0, 70) * tw;
      ey = org_y + $urandom_range(0, 70) * th;
    end
    ly = $urandom_range(1, nlay);
    it = add_item(sx < 0 ? 0 : sx, sy < 0 ? 0 : sy, ex, ey, ly, ly);
    if (k > 97) begin
      it = seg_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.op = OP_ADD;
    end else if (k == 90) it.l2 = $urandom;
    else if (k == 91) it.l1 = (it.l2 == 0) ? 0 : 9;
    return it;
  endfunction

  initial begin
    org_x = reda_pkg::ORIGIN_X_RST; org_y = reda_pkg::ORIGIN_Y_RST;
    tw = reda_pkg::TILE_W_RST; th = reda_pkg::TILE_H_RST;
    ncols = reda_pkg::COLS_RST; nrows = reda_pkg::ROWS_RST; nlay = reda_pkg::LAYERS_RST;
    foreach (horiz_cnt[i]) begin
      horiz_cnt[i] = 0;
      vert_cnt[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, extremes, every status.
    busy_cfg = 1'b0;
    pending_items.push_back(add_item(0, 5, 63, 5, 1, 1));         // full row
    pending_items.push_back(add_item(7, 0, 7, 63, 8, 8));         // full column
    pending_items.push_back(add_item(0, 0, 200, 0, 2, 2));        // beyond grid
    pending_items.push_back(add_item(3, 3, 3, 3, 1, 1));          // zero length
    pending_items.push_back(add_item(1, 1, 4, 1, 0, 0));          // layer zero
    pending_items.push_back(add_item(1, 1, 4, 1, 9, 9));          // layer above use
    pending_items.push_back(add_item(1, 1, 4, 1, 3, 4));          // via
    pending_items.push_back(add_item(1, 1, 4, 6, 3, 3));          // diagonal
    pending_items.push_back(add_item(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFF0,
                                     8'hFF, 8'hFF));
    pending_items.push_back(add_item(9, 70, 20, 70, 1, 1));       // fixed row outside
    pending_items.push_back(read_item(0, 5, 0));
    pending_items.push_back(read_item(7, 0, 1));
    pending_items.push_back(read_item(63, 63, 1));
    pending_items.push_back(read_item(62, 5, 0));
    pending_items.push_back(read_item(63, 5, 0));                 // outside
    drain();

    // Small grid, big tiles, origin offset: endpoints before the origin.
    program_grid(1000, 2000, 10, 7, 2, 2, 1);
    busy_cfg = 1'b0;
    pending_items.push_back(add_item(991, 2000, 1015, 2000, 1, 1));
    pending_items.push_back(add_item(1000, 1994, 1000, 2010, 1, 1));
    pending_items.push_back(read_item(0, 0, 0));
    pending_items.push_back(read_item(0, 0, 1));
    drain();

    // Zero tile size taken as one; repeated adds build up one edge (tile 0 layer 1).
    program_grid(0, 0, 0, 0, 3, 3, 1);
    busy_cfg = 1'b0;
    repeat (300) pending_items.push_back(add_item(0, 0, 1, 0, 1, 1));
    pending_items.push_back(read_item(0, 0, 0));
    drain();

    // Random phases across several settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_grid(0, 0, 1, 1, 64, 64, 8);
        1: program_grid(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 127, 127, 15);
        2: program_grid($urandom_range(0, 5000), $urandom_range(0, 5000),
                        $urandom_range(1, 40), $urandom_range(1, 40),
                        $urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(1, 8));
        3: program_grid(100, 50, 3, 5, 17, 9, 4);
        4: program_grid($urandom_range(0, 200), $urandom_range(0, 200), 2, 2, 64, 64, 0);
        default: program_grid(0, 0, 1, 1, 64, 64, 8);
      endcase
      busy_cfg = 1'b0;
      if (ph == 5) quiet = 1'b1;
      repeat (175) pending_items.push_back(random_item());
      // read back 40 random edges at the end of the last phase
      if (ph == 5) for (int i = 0; i < 40; i++)
        pending_items.push_back(read_item($urandom_range(0, 63), $urandom_range(0, 63), i % 2));
      drain();
    end

    if (mismatches == 0)
      $display("routing_edge_demand_accumulator_top_test: PASS");
    else
      $display("routing_edge_demand_accumulator_top_test: FAIL");
    $finish;
  end
endmodule
